// File: sv/tridiagonal_heat_row_solver_core_assert.svh
// Assertion macros for the row solver checker.
// Needs a clock clk and an active-low reset arst_n in scope.
`ifndef TRIDIAGONAL_HEAT_ROW_SOLVER_CORE_ASSERT_SVH
`define TRIDIAGONAL_HEAT_ROW_SOLVER_CORE_ASSERT_SVH

// pre holds at an edge, post holds at the same edge
`define THRS_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// pre holds at an edge, post holds at the next edge
`define THRS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

// File: sv/thrs_pkg.sv
// Shared types and constants of the tridiagonal row solver.
// No dependencies.
package thrs_pkg;

	localparam int FRAC_BITS = 24;
	localparam int FIELD_W   = 48;
	localparam int COEF_W    = 47;
	localparam int INDEX_W   = 6;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 64;

	localparam logic REG_GRID_COEF = 1'b0;
	localparam logic REG_INV_DT    = 1'b1;

	localparam logic [COEF_W-1:0] GRID_COEF_RST = 47'd3355443200;
	localparam logic [COEF_W-1:0] INV_DT_RST    = 47'd167772160;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULA,
		ST_MULB,
		ST_COEF,
		ST_MULD,
		ST_CHK,
		ST_MULO,
		ST_DIVR,
		ST_DIVO,
		ST_BS0,
		ST_EMIT,
		ST_BRD,
		ST_BMS,
		ST_BMUL
	} thrs_state_t;

endpackage

// File: sv/tridiagonal_heat_row_solver_core.sv
// Top level of the tridiagonal row solver: sweep sequencer, shared multiplier and divider,
// alpha/beta memories. Depends on thrs_pkg.
//
// channel   dir  handshake            word
// in        in   in_valid/in_stall    rhs, conductivity, boundaries, last_item
// out       out  out_valid/out_stall  node_index, solution, singular, last_result
// cfg       in   APB psel/penable     grid_coef @0, inv_time_step @8
//
// First and second item of a row: taken in idle, with no sweep step. Later items: one
// forward-sweep step, 4 multiplies and 2 divides (one quotient bit a cycle); a zero pivot
// ends the step after the third multiply. Back substitution: one multiply a word, and each
// word waits on out_stall. No clearing pass after reset; out_stall holds the output
// register and the sequencer waits on it.
module tridiagonal_heat_row_solver_core #(
	parameter int ROW_LENGTH_MAX = 64,
	parameter int VALUE_WIDTH    = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [thrs_pkg::FIELD_W-1:0]    rhs,
	input  logic        [thrs_pkg::COEF_W-1:0]     conductivity,
	input  logic signed [thrs_pkg::FIELD_W-1:0]    left_boundary,
	input  logic signed [thrs_pkg::FIELD_W-1:0]    right_boundary,
	input  logic                                   last_item,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [thrs_pkg::INDEX_W-1:0]    node_index,
	output logic signed [thrs_pkg::FIELD_W-1:0]    solution,
	output logic                                   singular,
	output logic                                   last_result,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [thrs_pkg::PADDR_W-1:0]    paddr,
	input  logic        [thrs_pkg::PDATA_W-1:0]    pwdata,
	output logic        [thrs_pkg::PDATA_W-1:0]    prdata,
	output logic                                   pready
);

	localparam int AW   = $clog2(ROW_LENGTH_MAX);
	localparam int VW   = VALUE_WIDTH;
	localparam int FB   = thrs_pkg::FRAC_BITS;
	localparam int OW   = (VW > thrs_pkg::COEF_W) ? VW : thrs_pkg::COEF_W;
	localparam int NCH  = (OW + 15) / 16;
	localparam int YW   = NCH * 16;
	localparam int CW   = $clog2(NCH + 1);
	localparam int PW   = 2 * OW;
	localparam int BW   = PW + 1;
	localparam int DW   = VW + FB;
	localparam int DCW  = $clog2(DW + 1);
	localparam int WW   = 66;

	// ---- arithmetic helpers
	function automatic logic signed [VW-1:0] fit_v(input logic signed [WW-1:0] x);
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		hi = $signed((WW'(1) << (VW - 1)) - WW'(1));
		lo = ~hi;
		if (x > hi)
			return hi[VW-1:0];
		else if (x < lo)
			return lo[VW-1:0];
		return x[VW-1:0];
	endfunction

	function automatic logic signed [thrs_pkg::FIELD_W-1:0] fit_f(input logic signed [WW-1:0] x);
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		hi = $signed((WW'(1) << (thrs_pkg::FIELD_W - 1)) - WW'(1));
		lo = ~hi;
		if (x > hi)
			return hi[thrs_pkg::FIELD_W-1:0];
		else if (x < lo)
			return lo[thrs_pkg::FIELD_W-1:0];
		return x[thrs_pkg::FIELD_W-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic [VW:0] s;
		s = {a[VW-1], a} + {b[VW-1], b};
		if (s[VW] != s[VW-1])
			return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		return s[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sneg(input logic signed [VW-1:0] a);
		if (a == {1'b1, {(VW-1){1'b0}}})
			return {1'b0, {(VW-1){1'b1}}};
		return -a;
	endfunction

	function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] a);
		logic [VW-1:0] u;
		u = a;
		return a[VW-1] ? (~u + VW'(1)) : u;
	endfunction

	function automatic logic signed [VW-1:0] sat_mag(input logic neg, input logic [BW-1:0] m);
		logic [BW-1:0] lim;
		logic [BW-1:0] mm;
		logic [VW-1:0] r;
		lim = (BW'(1) << (VW - 1)) - BW'(1) + BW'(neg);
		mm  = (m > lim) ? lim : m;
		r   = mm[VW-1:0];
		return neg ? (~r + VW'(1)) : r;
	endfunction

	// ---- configuration
	logic [thrs_pkg::COEF_W-1:0] grid_coef_q;
	logic [thrs_pkg::COEF_W-1:0] inv_dt_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_coef_q <= thrs_pkg::GRID_COEF_RST;
			inv_dt_q    <= thrs_pkg::INV_DT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				thrs_pkg::REG_GRID_COEF: grid_coef_q <= pwdata[thrs_pkg::COEF_W-1:0];
				thrs_pkg::REG_INV_DT:    inv_dt_q    <= pwdata[thrs_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			thrs_pkg::REG_GRID_COEF: prdata = thrs_pkg::PDATA_W'(grid_coef_q);
			thrs_pkg::REG_INV_DT:    prdata = thrs_pkg::PDATA_W'(inv_dt_q);
			default:                 prdata = '0;
		endcase
	end

	// ---- state
	thrs_pkg::thrs_state_t state_q, state_d;

	logic [AW-1:0]               node_count_q;
	logic                        pivot_q;
	logic [thrs_pkg::COEF_W-1:0] kp0_q, kp1_q;
	logic signed [VW-1:0]        pend_q, rhs_w_q, right_q;
	logic [thrs_pkg::COEF_W-2:0] sum_b_q;
	logic [AW-1:0]               waddr_q, raddr_q, bs_q;
	logic                        last_q;
	logic signed [VW-1:0]        a_q, b_q, c_q, den_q, num_o_q, ratio_new_q, y_q;

	logic signed [VW-1:0] ratio_mem  [ROW_LENGTH_MAX];
	logic signed [VW-1:0] offset_mem [ROW_LENGTH_MAX];
	logic signed [VW-1:0] ratio_rd_q, offset_rd_q;

	logic                        out_valid_q;
	logic [thrs_pkg::INDEX_W-1:0] node_index_q;
	logic signed [thrs_pkg::FIELD_W-1:0] solution_q;
	logic                        singular_q, last_result_q;

	logic                        in_acc, last_in;
	logic [AW-1:0]               k;
	logic [thrs_pkg::COEF_W:0]   sum_a_full, sum_b_full;

	assign in_stall = (state_q != thrs_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign k        = node_count_q;
	assign last_in  = last_item || (k == AW'(ROW_LENGTH_MAX - 1));
	assign sum_a_full = {1'b0, kp0_q} + {1'b0, kp1_q};
	assign sum_b_full = {1'b0, kp1_q} + {1'b0, conductivity};

	// ---- shared multiplier, 16 bits of y a cycle
	logic                 mul_go, mul_neg_d, mul_done;
	logic [OW-1:0]        mul_x_d, mul_y_d;
	logic [OW-1:0]        mul_x_q;
	logic [YW-1:0]        mul_y_q;
	logic                 mul_neg_q;
	logic [PW-1:0]        mul_acc_q;
	logic [CW-1:0]        mul_cnt_q;
	logic [OW+15:0]       mul_part;
	logic [BW-1:0]        mul_rnd;
	logic signed [VW-1:0] mul_res;

	assign mul_done = (mul_cnt_q == CW'(NCH));
	assign mul_part = mul_x_q * mul_y_q[15:0];
	assign mul_rnd  = (BW'(mul_acc_q) + (BW'(1) << (FB - 1))) >> FB;
	assign mul_res  = sat_mag(mul_neg_q, mul_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mul_cnt_q <= CW'(NCH);
		else if (mul_go)
			mul_cnt_q <= '0;
		else if (!mul_done)
			mul_cnt_q <= mul_cnt_q + CW'(1);
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_x_q   <= mul_x_d;
			mul_y_q   <= YW'(mul_y_d);
			mul_neg_q <= mul_neg_d;
			mul_acc_q <= '0;
		end else if (!mul_done) begin
			mul_acc_q <= mul_acc_q + (PW'(mul_part) << {mul_cnt_q, 4'b0000});
			mul_y_q   <= mul_y_q >> 16;
		end
	end

	// ---- shared divider, restoring, one quotient bit a cycle
	logic                 div_go, div_done;
	logic signed [VW-1:0] div_num_d, div_den_d;
	logic [VW-1:0]        div_d_q, div_r_q;
	logic [DW-1:0]        div_q_q;
	logic                 div_neg_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [VW:0]          div_r2, div_diff;
	logic                 div_ge;
	logic signed [VW-1:0] div_res;

	assign div_done = (div_cnt_q == DCW'(DW));
	assign div_r2   = {div_r_q, div_q_q[DW-1]};
	assign div_diff = div_r2 - {1'b0, div_d_q};
	assign div_ge   = (div_r2 >= {1'b0, div_d_q});
	assign div_res  = sat_mag(div_neg_q, BW'(div_q_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= DCW'(DW);
		else if (div_go)
			div_cnt_q <= '0;
		else if (!div_done)
			div_cnt_q <= div_cnt_q + DCW'(1);
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_d_q   <= mag_v(div_den_d);
			div_r_q   <= '0;
			div_q_q   <= {mag_v(div_num_d), {FB{1'b0}}};
			div_neg_q <= div_num_d[VW-1] ^ div_den_d[VW-1];
		end else if (!div_done) begin
			div_r_q <= div_ge ? div_diff[VW-1:0] : div_r2[VW-1:0];
			div_q_q <= {div_q_q[DW-2:0], div_ge};
		end
	end

	// ---- sequencer
	logic                 mem_we, out_load;
	logic [AW-1:0]        mem_waddr;
	logic signed [VW-1:0] ratio_wd, offset_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= thrs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		mul_go    = 1'b0;
		mul_neg_d = 1'b0;
		mul_x_d   = '0;
		mul_y_d   = '0;
		div_go    = 1'b0;
		div_num_d = '0;
		div_den_d = '0;
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		ratio_wd  = '0;
		offset_wd = '0;
		out_load  = 1'b0;
		unique case (state_q)
			thrs_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (k == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						offset_wd = fit_v(WW'(left_boundary));
					end
					if (k >= AW'(2)) begin
						mul_go  = 1'b1;
						mul_x_d = OW'(sum_a_full[thrs_pkg::COEF_W:2]);
						mul_y_d = OW'(grid_coef_q);
						state_d = thrs_pkg::ST_MULA;
					end else if (last_in) begin
						state_d = thrs_pkg::ST_BS0;
					end
				end
			end
			thrs_pkg::ST_MULA: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_x_d = OW'(sum_b_q);
					mul_y_d = OW'(grid_coef_q);
					state_d = thrs_pkg::ST_MULB;
				end
			end
			thrs_pkg::ST_MULB: begin
				if (mul_done)
					state_d = thrs_pkg::ST_COEF;
			end
			thrs_pkg::ST_COEF: begin
				mul_go    = 1'b1;
				mul_neg_d = a_q[VW-1] ^ ratio_rd_q[VW-1];
				mul_x_d   = OW'(mag_v(a_q));
				mul_y_d   = OW'(mag_v(ratio_rd_q));
				state_d   = thrs_pkg::ST_MULD;
			end
			thrs_pkg::ST_MULD: begin
				if (mul_done)
					state_d = thrs_pkg::ST_CHK;
			end
			thrs_pkg::ST_CHK: begin
				if (den_q == '0) begin
					mem_we  = 1'b1;
					state_d = last_q ? thrs_pkg::ST_BS0 : thrs_pkg::ST_IDLE;
				end else begin
					mul_go    = 1'b1;
					mul_neg_d = a_q[VW-1] ^ offset_rd_q[VW-1];
					mul_x_d   = OW'(mag_v(a_q));
					mul_y_d   = OW'(mag_v(offset_rd_q));
					state_d   = thrs_pkg::ST_MULO;
				end
			end
			thrs_pkg::ST_MULO: begin
				if (mul_done) begin
					div_go    = 1'b1;
					div_num_d = sneg(b_q);
					div_den_d = den_q;
					state_d   = thrs_pkg::ST_DIVR;
				end
			end
			thrs_pkg::ST_DIVR: begin
				if (div_done) begin
					div_go    = 1'b1;
					div_num_d = num_o_q;
					div_den_d = den_q;
					state_d   = thrs_pkg::ST_DIVO;
				end
			end
			thrs_pkg::ST_DIVO: begin
				if (div_done) begin
					mem_we    = 1'b1;
					ratio_wd  = ratio_new_q;
					offset_wd = div_res;
					state_d   = last_q ? thrs_pkg::ST_BS0 : thrs_pkg::ST_IDLE;
				end
			end
			thrs_pkg::ST_BS0: state_d = thrs_pkg::ST_EMIT;
			thrs_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = (bs_q == '0) ? thrs_pkg::ST_IDLE : thrs_pkg::ST_BRD;
				end
			end
			thrs_pkg::ST_BRD: state_d = thrs_pkg::ST_BMS;
			thrs_pkg::ST_BMS: begin
				mul_go    = 1'b1;
				mul_neg_d = ratio_rd_q[VW-1] ^ y_q[VW-1];
				mul_x_d   = OW'(mag_v(ratio_rd_q));
				mul_y_d   = OW'(mag_v(y_q));
				state_d   = thrs_pkg::ST_BMUL;
			end
			thrs_pkg::ST_BMUL: begin
				if (mul_done)
					state_d = thrs_pkg::ST_EMIT;
			end
			default: state_d = thrs_pkg::ST_IDLE;
		endcase
	end

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			pivot_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc)
				node_count_q <= last_in ? '0 : k + AW'(1);
			if (in_acc && k == '0)
				pivot_q <= 1'b0;
			else if (state_q == thrs_pkg::ST_CHK && den_q == '0)
				pivot_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// ---- datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kp0_q   <= kp1_q;
			kp1_q   <= conductivity;
			pend_q  <= fit_v(WW'(rhs));
			rhs_w_q <= pend_q;
			sum_b_q <= sum_b_full[thrs_pkg::COEF_W:2];
			waddr_q <= k - AW'(1);
			raddr_q <= k - AW'(2);
			bs_q    <= k;
			last_q  <= last_in;
			if (k == '0)
				right_q <= fit_v(WW'(right_boundary));
		end
		case (state_q)
			thrs_pkg::ST_MULA: if (mul_done) a_q <= sneg(mul_res);
			thrs_pkg::ST_MULB: if (mul_done) b_q <= sneg(mul_res);
			thrs_pkg::ST_COEF: c_q <= sadd(sadd(fit_v(WW'(inv_dt_q)), sneg(a_q)), sneg(b_q));
			thrs_pkg::ST_MULD: if (mul_done) den_q <= sadd(c_q, mul_res);
			thrs_pkg::ST_MULO: if (mul_done) num_o_q <= sadd(rhs_w_q, sneg(mul_res));
			thrs_pkg::ST_DIVR: if (div_done) ratio_new_q <= div_res;
			thrs_pkg::ST_BS0:  y_q <= right_q;
			thrs_pkg::ST_EMIT: begin
				if (out_load && bs_q != '0) begin
					bs_q    <= bs_q - AW'(1);
					raddr_q <= bs_q - AW'(1);
				end
			end
			thrs_pkg::ST_BMUL: if (mul_done) y_q <= sadd(mul_res, offset_rd_q);
			default: ;
		endcase
		if (out_load) begin
			node_index_q  <= thrs_pkg::INDEX_W'(bs_q);
			solution_q    <= fit_f(WW'(y_q));
			singular_q    <= pivot_q;
			last_result_q <= (bs_q == '0);
		end
	end

	// ---- alpha / beta memories
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ratio_mem[mem_waddr]  <= ratio_wd;
			offset_mem[mem_waddr] <= offset_wd;
		end
		ratio_rd_q  <= ratio_mem[raddr_q];
		offset_rd_q <= offset_mem[raddr_q];
	end

	assign out_valid   = out_valid_q;
	assign node_index  = node_index_q;
	assign solution    = solution_q;
	assign singular    = singular_q;
	assign last_result = last_result_q;

endmodule

// File: sv/thrs_checker.sv
// Port-level checks for the row solver, bound to the top level.
// Uses tridiagonal_heat_row_solver_core_assert.svh and thrs_pkg.
`include "tridiagonal_heat_row_solver_core_assert.svh"

module thrs_port_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [thrs_pkg::INDEX_W-1:0]        node_index,
	input logic signed [thrs_pkg::FIELD_W-1:0] solution,
	input logic                                last_result
);

	`THRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(solution) && $stable(node_index), "stalled word changed")
	`THRS_ASSERT_SAME(a_last_node0, out_valid, last_result == (node_index == '0), "last_result not on node zero")
	`THRS_ASSERT_SAME(a_busy_in_run, out_valid && !last_result, in_stall, "input taken mid back substitution")

endmodule

bind tridiagonal_heat_row_solver_core thrs_port_checker u_thrs_checker (.*);

// File: bench/thrs_checker.sv
// Checker for the tridiagonal row solver: follows register writes and accepted
// input words, predicts each row's solutions and compares the output words.
// Depends on thrs_pkg.
module thrs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [thrs_pkg::FIELD_W-1:0] rhs,
	input  logic        [thrs_pkg::COEF_W-1:0]  conductivity,
	input  logic signed [thrs_pkg::FIELD_W-1:0] left_boundary,
	input  logic signed [thrs_pkg::FIELD_W-1:0] right_boundary,
	input  logic                                last_item,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic        [thrs_pkg::INDEX_W-1:0] node_index,
	input  logic signed [thrs_pkg::FIELD_W-1:0] solution,
	input  logic                                singular,
	input  logic                                last_result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [thrs_pkg::PADDR_W-1:0] paddr,
	input  logic        [thrs_pkg::PDATA_W-1:0] pwdata,
	input  logic                                pready,
	output int                                  fail_count,
	output int                                  pending
);
	localparam int FIELD_W   = thrs_pkg::FIELD_W;
	localparam int COEF_W    = thrs_pkg::COEF_W;
	localparam int INDEX_W   = thrs_pkg::INDEX_W;
	localparam int FRAC_BITS = thrs_pkg::FRAC_BITS;

	localparam int ROW_MAX = 64;

	typedef logic signed [FIELD_W-1:0] val_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [INDEX_W-1:0] idx;
		val_t               sol;
		logic               sing;
		logic               fin;
	} node_sol_t;

	localparam val_t VMAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam val_t VMIN = {1'b1, {(FIELD_W-1){1'b0}}};

	node_sol_t           expected_solutions[$];
	logic [COEF_W-1:0]   grid_coef_q, inv_dt_q;
	val_t                ratio[ROW_MAX], offset[ROW_MAX];
	logic [COEF_W-1:0]   k_prev[2];
	val_t                rhs_prev, right_val;
	int                  node_cnt;
	logic                pivot_err;

	function automatic val_t sat(wide_t v);
		if (v > wide_t'(VMAX))
			return VMAX;
		if (v < wide_t'(VMIN))
			return VMIN;
		return val_t'(v);
	endfunction

	function automatic logic [127:0] magn(val_t a);
		wide_t s;
		s = a;
		return (s < 0) ? -s : s;
	endfunction

	function automatic val_t from_magn(logic neg, logic [127:0] m);
		wide_t s;
		if (neg) begin
			if (m > 128'(VMAX) + 1)
				return VMIN;
			s = m;
			return val_t'(-s);
		end
		if (m > 128'(VMAX))
			return VMAX;
		return val_t'(m);
	endfunction

	function automatic val_t fx_add(val_t a, val_t b);
		wide_t s;
		s = a;
		s = s + b;
		return sat(s);
	endfunction

	function automatic val_t fx_neg(val_t a);
		wide_t s;
		s = a;
		return sat(-s);
	endfunction

	function automatic val_t fx_mul(val_t a, val_t b);
		logic [127:0] m;
		m = magn(a) * magn(b);
		m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return from_magn(a[FIELD_W-1] ^ b[FIELD_W-1], m);
	endfunction

	function automatic val_t fx_div(val_t n, val_t d);
		logic [127:0] m;
		m = (magn(n) << FRAC_BITS) / magn(d);
		return from_magn(n[FIELD_W-1] ^ d[FIELD_W-1], m);
	endfunction

	function automatic val_t avg_k(logic [COEF_W-1:0] x, logic [COEF_W-1:0] y);
		logic [FIELD_W-1:0] s;
		s = {1'b0, x} + {1'b0, y};
		return val_t'(s >> 2);
	endfunction

	task automatic sweep_step(int i, logic [COEF_W-1:0] km, logic [COEF_W-1:0] kc,
			logic [COEF_W-1:0] kp);
		val_t g, a, b, c, den;
		g   = val_t'({1'b0, grid_coef_q});
		a   = fx_neg(fx_mul(avg_k(km, kc), g));
		b   = fx_neg(fx_mul(avg_k(kc, kp), g));
		c   = fx_add(fx_add(val_t'({1'b0, inv_dt_q}), fx_neg(a)), fx_neg(b));
		den = fx_add(c, fx_mul(a, ratio[i-1]));
		if (den == 0) begin
			pivot_err = 1'b1;
			ratio[i]  = '0;
			offset[i] = '0;
		end else begin
			ratio[i]  = fx_div(fx_neg(b), den);
			offset[i] = fx_div(fx_add(rhs_prev, fx_neg(fx_mul(a, offset[i-1]))), den);
		end
	endtask

	task automatic take_node();
		int        k;
		val_t      y;
		node_sol_t e;
		k = (node_cnt >= ROW_MAX) ? ROW_MAX - 1 : node_cnt;
		if (k == 0) begin
			pivot_err = 1'b0;
			ratio[0]  = '0;
			offset[0] = left_boundary;
			right_val = right_boundary;
		end else if (k >= 2) begin
			sweep_step(k - 1, k_prev[0], k_prev[1], conductivity);
		end
		k_prev[0] = k_prev[1];
		k_prev[1] = conductivity;
		rhs_prev  = rhs;
		if (!last_item && k != ROW_MAX - 1) begin
			node_cnt = k + 1;
			return;
		end
		y = right_val;
		for (int i = k; i >= 0; i--) begin
			if (i < k)
				y = fx_add(fx_mul(ratio[i], y), offset[i]);
			e.idx  = INDEX_W'(i);
			e.sol  = y;
			e.sing = pivot_err;
			e.fin  = (i == 0);
			expected_solutions.push_back(e);
		end
		node_cnt = 0;
	endtask

	task automatic check_word();
		node_sol_t e;
		if (expected_solutions.size() == 0) begin
			$error("unexpected output word, node_index %0d", node_index);
			fail_count++;
			return;
		end
		e = expected_solutions.pop_front();
		if (node_index !== e.idx) begin
			$error("node_index expected %0d got %0d", e.idx, node_index);
			fail_count++;
		end
		if (solution !== e.sol) begin
			$error("solution expected %0d got %0d", e.sol, solution);
			fail_count++;
		end
		if (singular !== e.sing) begin
			$error("singular expected %0b got %0b", e.sing, singular);
			fail_count++;
		end
		if (last_result !== e.fin) begin
			$error("last_result expected %0b got %0b", e.fin, last_result);
			fail_count++;
		end
	endtask

	initial begin
		grid_coef_q = thrs_pkg::GRID_COEF_RST;
		inv_dt_q    = thrs_pkg::INV_DT_RST;
		k_prev[0]   = '0;
		k_prev[1]   = '0;
		rhs_prev    = '0;
		right_val   = '0;
		node_cnt    = 0;
		pivot_err   = 1'b0;
		for (int i = 0; i < ROW_MAX; i++) begin
			ratio[i]  = '0;
			offset[i] = '0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == thrs_pkg::REG_GRID_COEF)
					grid_coef_q = pwdata[COEF_W-1:0];
				else if (paddr[3] == thrs_pkg::REG_INV_DT)
					inv_dt_q = pwdata[COEF_W-1:0];
			end
			if (in_valid && !in_stall)
				take_node();
			if (out_valid && !out_stall)
				check_word();
		end
		pending = expected_solutions.size();
	end

endmodule

// File: bench/tb_top.sv
// Top of the row solver bench: clock, reset, register writes, input words in
// bursts, output stalls and the verdict. Depends on thrs_pkg, thrs_checker and
// tridiagonal_heat_row_solver_core.
module tb_top;
	localparam int FIELD_W = thrs_pkg::FIELD_W;
	localparam int COEF_W  = thrs_pkg::COEF_W;
	localparam int INDEX_W = thrs_pkg::INDEX_W;
	localparam int PADDR_W = thrs_pkg::PADDR_W;
	localparam int PDATA_W = thrs_pkg::PDATA_W;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 400;
	localparam int HOLD_LEN    = 4000;
	localparam int ITEMS       = 260;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [FIELD_W-1:0]   rhs = '0;
	logic        [COEF_W-1:0]    conductivity = '0;
	logic signed [FIELD_W-1:0]   left_boundary = '0;
	logic signed [FIELD_W-1:0]   right_boundary = '0;
	logic                        last_item = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic        [INDEX_W-1:0]   node_index;
	logic signed [FIELD_W-1:0]   solution;
	logic                        singular;
	logic                        last_result;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic        [PADDR_W-1:0]   paddr = '0;
	logic        [PDATA_W-1:0]   pwdata = '0;
	logic        [PDATA_W-1:0]   prdata;
	logic                        pready;
	int                          fail_count;
	int                          pending;
	int                          cycles = 0;
	int                          burst_left = 0;
	int                          words_sent = 0;
	logic                        hold_req = 1'b0;

	tridiagonal_heat_row_solver_core dut (.*);

	thrs_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: stall pattern changing every stretch, one long hold-off once a word waits
	initial begin
		int mode, stretch;
		bit held;
		held = 0;
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(10, 300);
			repeat (stretch) begin
				@(negedge clk);
				if (hold_req && !held && out_valid) begin
					held      = 1;
					out_stall = 1'b1;
					repeat (HOLD_LEN - 1) @(negedge clk);
				end
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = $urandom_range(0, 1);
				endcase
			end
		end
	end

	function automatic logic [FIELD_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[FIELD_W-1:0];
	endfunction

	task automatic reg_write(logic idx, logic [COEF_W-1:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = {{(PDATA_W-COEF_W){1'b1}}, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic configure(logic [COEF_W-1:0] g, logic [COEF_W-1:0] t);
		drain();
		reg_write(thrs_pkg::REG_GRID_COEF, g);
		reg_write(thrs_pkg::REG_INV_DT, t);
	endtask

	// one word; sender may go idle between bursts
	task automatic send_node(logic [FIELD_W-1:0] r, logic [COEF_W-1:0] k,
			logic [FIELD_W-1:0] lb, logic [FIELD_W-1:0] rb, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid       = 1'b1;
		rhs            = r;
		conductivity   = k;
		left_boundary  = lb;
		right_boundary = rb;
		last_item      = fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_row(int len, bit force_last);
		logic [COEF_W-1:0] k;
		logic [63:0] w;
		int style;
		style = $urandom_range(0, 3);
		for (int i = 0; i < len; i++) begin
			w = {$urandom, $urandom};
			case (style)
				0: k = w[COEF_W-1:0];
				1: k = COEF_W'($urandom_range(0, 32'h0400_0000));
				2: k = '0;
				default: k = COEF_W'($urandom_range(0, 32'h00ff_ffff));
			endcase
			send_node(($urandom_range(0, 1) != 0) ? rand48() : 48'($signed($urandom) >>> 4),
				k, rand48(), rand48(), force_last && (i == len - 1));
		end
	endtask

	initial begin
		int len;
		logic [63:0] wg, wt;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: short rows, extremes
		send_node({1'b0, {47{1'b1}}}, '0, {1'b1, 47'd0}, {1'b0, {47{1'b1}}}, 1'b1);
		send_node(48'd5, 47'd16777216, 48'd16777216, -48'sd33554432, 1'b0);
		send_node(48'd7, 47'd16777216, 48'd1, 48'd2, 1'b1);
		send_node('0, {47{1'b1}}, 48'd50331648, -48'sd16777216, 1'b0);
		send_node({1'b1, 47'd0}, {47{1'b1}}, '0, '0, 1'b0);
		send_node({1'b0, {47{1'b1}}}, {47{1'b1}}, '0, '0, 1'b1);
		configure({COEF_W{1'b1}}, {COEF_W{1'b1}});
		send_node(rand48(), {47{1'b1}}, {1'b0, {47{1'b1}}}, {1'b1, 47'd0}, 1'b0);
		send_node({1'b1, 47'd0}, 47'd1, '0, '0, 1'b0);
		send_node({1'b0, {47{1'b1}}}, 47'd3, '0, '0, 1'b0);
		send_node(rand48(), {47{1'b1}}, '0, '0, 1'b1);
		// zero pivot: no conduction and no time term
		configure('0, '0);
		send_node(48'd1, '0, 48'd16777216, 48'd33554432, 1'b0);
		send_node(48'd2, '0, '0, '0, 1'b0);
		send_node(48'd3, '0, '0, '0, 1'b0);
		send_node(48'd4, '0, '0, '0, 1'b1);
		configure(thrs_pkg::GRID_COEF_RST, thrs_pkg::INV_DT_RST);
		send_row(5, 1);

		// row overflow under a long output hold-off
		hold_req = 1'b1;
		send_row(70, 0);
		send_node(rand48(), 47'd16777216, rand48(), rand48(), 1'b1);

		while (words_sent < ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				wg = {$urandom, $urandom};
				wt = {$urandom, $urandom};
				case ($urandom_range(0, 3))
					0: configure(wg[COEF_W-1:0], wt[COEF_W-1:0]);
					1: configure(COEF_W'($urandom_range(0, 32'h4000_0000)),
						COEF_W'($urandom_range(0, 32'h4000_0000)));
					2: configure('0, COEF_W'($urandom_range(1, 32'h1000_0000)));
					default: configure(thrs_pkg::GRID_COEF_RST, thrs_pkg::INV_DT_RST);
				endcase
			end
			len = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(1, 8);
			if (len > ITEMS - words_sent)
				len = ITEMS - words_sent;
			send_row(len, 1);
		end
		drain();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
